// ----- hdl/mpf_pkg.sv -----
// Shared constants, payload types and line store write bundle for the midpoint filter.
`default_nettype none

package mpf_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 2048;
  localparam int KERNEL_SIZE = 3;
  localparam int CHANNELS    = 3;
  localparam int CH_W        = 8;
  localparam int PIX_W       = CH_W * CHANNELS;
  localparam int ADDR_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int COORD_W     = 11;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int MIN_DIM     = 3;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
  localparam int RES_LAT     = 4;   // stages from window shift to queue push

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    chan_t chan_a;
    chan_t chan_b;
    chan_t chan_c;
  } pix_in_t;

  typedef struct packed {
    chan_t              out_a;
    chan_t              out_b;
    chan_t              out_c;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
  } result_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } coord_t;

  // One line store entry: row r-2 in the upper half, row r-1 in the lower half.
  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [2*PIX_W-1:0] data;
  } lsw_t;

endpackage

`default_nettype wire

// ----- hdl/midpoint_filter_3x3_rgb.sv -----
// Top level of the 3x3 midpoint filter for three-channel 8-bit pixel streams.
//
// Pixels enter in raster order, one word per clock on the input channel. For
// every pixel at row r, column c with r >= 2 and c >= 2 the block delivers one
// word holding, per channel, the rounded midpoint (max + min) / 2 of the 3x3
// window centred at (r-1, c-1), plus that centre's coordinates; border pixels
// give no word. Throughput is one pixel per clock while in_stall is low, set by the
// line store, a 2048 x 48 memory with one write and one registered read port that
// is read-modified-written once per pixel. A pixel passes the line store read
// register, the window shift register and the row reduction, window reduction and
// midpoint registers of the per-channel min/max/round lanes, then enters the result
// queue. The 8-word result queue decouples the output: input stall rises only when
// eight results are owed downstream (queued or in flight). image_width and
// image_height are clamped to [3, 2048]; writing either register restarts the frame
// at row 0, column 0, and must happen only while the block is idle. The line store
// needs no clearing: rows 0 and 1 of each frame fill every entry a result reads.
`default_nettype none

module midpoint_filter_3x3_rgb
  import mpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input pixel channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pix_in_t              in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output result_t              out_data,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // ------------------------------------------------------------------
  // Frame geometry, kept as last column / last row index.
  // ------------------------------------------------------------------
  logic [ADDR_W-1:0] width_last;
  logic [ROW_W-1:0]  height_last;
  logic [ADDR_W-1:0] col_count;
  logic [ROW_W-1:0]  row_count;
  logic              cfg_hit;

  function automatic logic [ADDR_W-1:0] width_last_of(input logic [CFG_W-1:0] v);
    logic [ADDR_W-1:0] res;
    if (int'(v) < MIN_DIM) begin
      res = ADDR_W'(MIN_DIM - 1);
    end else if (int'(v) > MAX_WIDTH) begin
      res = ADDR_W'(MAX_WIDTH - 1);
    end else begin
      res = ADDR_W'(v - CFG_W'(1));
    end
    return res;
  endfunction

  function automatic logic [ROW_W-1:0] height_last_of(input logic [CFG_W-1:0] v);
    logic [ROW_W-1:0] res;
    if (int'(v) < MIN_DIM) begin
      res = ROW_W'(MIN_DIM - 1);
    end else if (int'(v) > MAX_HEIGHT) begin
      res = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      res = ROW_W'(v - CFG_W'(1));
    end
    return res;
  endfunction

  assign cfg_hit = cfg_we &&
                   (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= ADDR_W'(WIDTH_RESET - 1);
      height_last <= ROW_W'(HEIGHT_RESET - 1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_last  <= width_last_of(cfg_data);
        REG_IMAGE_HEIGHT: height_last <= height_last_of(cfg_data);
        default: ;        // drop writes beyond the register list
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Input acceptance and raster position.
  // ------------------------------------------------------------------
  logic               in_accept;
  logic               emit_now;
  logic [FIFO_CW-1:0] credits;
  logic               pop;
  logic               push;

  // Stall once every queue slot is promised to a result.
  assign in_stall  = (credits == FIFO_CW'(FIFO_DEPTH));
  assign in_accept = in_valid && !in_stall;
  assign emit_now  = (row_count >= ROW_W'(KERNEL_SIZE - 1)) &&
                     (col_count >= ADDR_W'(KERNEL_SIZE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cfg_hit) begin
      // restart the frame on a write to either size register
      col_count <= '0;
      row_count <= '0;
    end else if (in_accept) begin
      if (col_count == width_last) begin
        col_count <= '0;
        row_count <= (row_count == height_last) ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + ADDR_W'(1);
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: line store read returns; write back the shifted rows.
  // ------------------------------------------------------------------
  logic               v1;
  logic               e1;
  pix_t               cur1;
  logic [ADDR_W-1:0]  addr1;
  coord_t             crd1;
  logic [2*PIX_W-1:0] ls_rd;
  lsw_t               ls_wr;
  pix_t               top_pix, mid_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur1     <= {in_data.chan_c, in_data.chan_b, in_data.chan_a};
      e1       <= emit_now;
      addr1    <= col_count;
      crd1.row <= COORD_W'(row_count - ROW_W'(1));
      crd1.col <= COORD_W'(col_count - ADDR_W'(1));
    end
  end

  assign top_pix    = ls_rd[2*PIX_W-1:PIX_W];
  assign mid_pix    = ls_rd[PIX_W-1:0];
  assign ls_wr.en   = v1;
  assign ls_wr.addr = addr1;
  assign ls_wr.data = {mid_pix, cur1};   // previous row moves up, current row enters

  mpf_line_store u_line_store (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (col_count),
    .rd_data (ls_rd),
    .wr      (ls_wr)
  );

  // ------------------------------------------------------------------
  // 3x3 window: advance one column per pixel.
  // ------------------------------------------------------------------
  pix_t win [KERNEL_SIZE][KERNEL_SIZE];

  always_ff @(posedge clk) begin
    if (v1) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
          win[i][j] <= win[i][j+1];
        end
      end
      win[0][KERNEL_SIZE-1] <= top_pix;
      win[1][KERNEL_SIZE-1] <= mid_pix;
      win[2][KERNEL_SIZE-1] <= cur1;
    end
  end

  // ------------------------------------------------------------------
  // Channel lanes: one min/max/midpoint unit per channel.
  // ------------------------------------------------------------------
  chan_t lane_px  [CHANNELS][KERNEL_SIZE][KERNEL_SIZE];
  chan_t lane_mid [CHANNELS];

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        for (int j = 0; j < KERNEL_SIZE; j++) begin
          lane_px[ch][i][j] = win[i][j][ch*CH_W +: CH_W];
        end
      end
    end
  end

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
    mpf_lane u_lane (
      .clk (clk),
      .px  (lane_px[ch]),
      .mid (lane_mid[ch])
    );
  end

  // ------------------------------------------------------------------
  // Track which cycles carry a result, and their coordinates, alongside
  // the lanes.
  // ------------------------------------------------------------------
  logic [RES_LAT-1:0] emit_sr;
  coord_t             crd_sr [RES_LAT];
  result_t            push_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_sr <= '0;
    end else begin
      emit_sr <= {emit_sr[RES_LAT-2:0], v1 && e1};
    end
  end

  always_ff @(posedge clk) begin
    crd_sr[0] <= crd1;
    for (int k = 1; k < RES_LAT; k++) begin
      crd_sr[k] <= crd_sr[k-1];
    end
  end

  // Merge the lane results with the centre coordinates into one word.
  assign push = emit_sr[RES_LAT-1];
  always_comb begin
    push_data.out_a   = lane_mid[0];
    push_data.out_b   = lane_mid[1];
    push_data.out_c   = lane_mid[2];
    push_data.out_row = crd_sr[RES_LAT-1].row;
    push_data.out_col = crd_sr[RES_LAT-1].col;
  end

  mpf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // ------------------------------------------------------------------
  // Queue credits: take one when a result-bearing pixel is accepted,
  // return one when a word leaves.
  // ------------------------------------------------------------------
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
    end else begin
      credits <= credits + FIFO_CW'(in_accept && emit_now) - FIFO_CW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credits <= FIFO_CW'(FIFO_DEPTH))
    else $error("credit count above queue depth");

  a_push_has_credit: assert property (@(posedge clk) disable iff (rst)
    push |-> (credits != '0))
    else $error("result pushed without a credit");

  a_inflight_covered: assert property (@(posedge clk) disable iff (rst)
    ($countones(emit_sr) + int'(v1 && e1)) <= int'(credits))
    else $error("results in flight exceed credits taken");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    col_count <= width_last)
    else $error("column counter beyond row width");
`endif

endmodule

`default_nettype wire

// ----- hdl/mpf_line_store.sv -----
// Two-row line store: one write port and one registered read port.
`default_nettype none

module mpf_line_store
  import mpf_pkg::*;
(
  input  logic               clk,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [2*PIX_W-1:0] rd_data,
  input  lsw_t               wr
);

  logic [2*PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mpf_lane.sv -----
// One channel lane: 3x3 minimum and maximum over two stages, then midpoint rounded half to even.
`default_nettype none

module mpf_lane
  import mpf_pkg::*;
(
  input  logic  clk,
  input  chan_t px [KERNEL_SIZE][KERNEL_SIZE],
  output chan_t mid
);

  chan_t row_lo [KERNEL_SIZE];
  chan_t row_hi [KERNEL_SIZE];
  chan_t row_lo_next [KERNEL_SIZE];
  chan_t row_hi_next [KERNEL_SIZE];
  chan_t win_lo, win_hi;
  chan_t win_lo_next, win_hi_next;
  logic [CH_W:0] sum;
  chan_t half;
  chan_t mid_next;

  // Stage A: reduce each window row.
  always_comb begin
    for (int i = 0; i < KERNEL_SIZE; i++) begin
      row_lo_next[i] = px[i][0];
      row_hi_next[i] = px[i][0];
      for (int j = 1; j < KERNEL_SIZE; j++) begin
        if (px[i][j] < row_lo_next[i]) row_lo_next[i] = px[i][j];
        if (px[i][j] > row_hi_next[i]) row_hi_next[i] = px[i][j];
      end
    end
  end

  // Stage B: reduce the row results.
  always_comb begin
    win_lo_next = row_lo[0];
    win_hi_next = row_hi[0];
    for (int i = 1; i < KERNEL_SIZE; i++) begin
      if (row_lo[i] < win_lo_next) win_lo_next = row_lo[i];
      if (row_hi[i] > win_hi_next) win_hi_next = row_hi[i];
    end
  end

  // Stage C: halve the sum; an odd sum over an odd half rounds up to even.
  always_comb begin
    sum      = {1'b0, win_lo} + {1'b0, win_hi};
    half     = sum[CH_W:1];
    mid_next = (sum[0] && half[0]) ? half + chan_t'(1) : half;
  end

  always_ff @(posedge clk) begin
    row_lo <= row_lo_next;
    row_hi <= row_hi_next;
    win_lo <= win_lo_next;
    win_hi <= win_hi_next;
    mid    <= mid_next;
  end

endmodule

`default_nettype wire

// ----- hdl/mpf_out_fifo.sv -----
// Result queue in front of the output channel.
`default_nettype none

module mpf_out_fifo
  import mpf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  result_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + FIFO_AW'(1);
      case ({push, pop})
        2'b10:   count <= count + FIFO_CW'(1);
        2'b01:   count <= count - FIFO_CW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != FIFO_CW'(FIFO_DEPTH) || pop))
    else $error("result queue overflow");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - FIFO_CW'(1)))
    else $error("result queue count did not drop on pop");

  a_stall_holds_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result word changed");
`endif

endmodule

`default_nettype wire

// ----- tb/mpf_scoreboard_pkg.sv -----
// Scoreboard class: predicts midpoint filter words and checks the block's results against them.
`default_nettype none

package mpf_scoreboard_pkg;

  import mpf_pkg::*;

  class midpoint_scoreboard;

    pix_in_t          prev_row  [MAX_WIDTH];
    pix_in_t          older_row [MAX_WIDTH];
    pix_in_t          win [KERNEL_SIZE][KERNEL_SIZE];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    result_t          owed_words [$];
    int unsigned      errors;

    function new();
      foreach (prev_row[k]) begin
        prev_row[k]  = '0;
        older_row[k] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = CFG_W'(WIDTH_RESET);
      height_reg = CFG_W'(HEIGHT_RESET);
      errors     = 0;
    endfunction

    function int unsigned clamp_dim(logic [CFG_W-1:0] raw, int unsigned top);
      if (raw < MIN_DIM) return MIN_DIM;
      if (raw > top) return top;
      return raw;
    endfunction

    function int unsigned eff_width();
      return clamp_dim(width_reg, MAX_WIDTH);
    endfunction

    function int unsigned eff_height();
      return clamp_dim(height_reg, MAX_HEIGHT);
    endfunction

    function int unsigned pending();
      return owed_words.size();
    endfunction

    // Any write to a listed register restarts the frame; spare indexes do nothing.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = val;
        REG_IMAGE_HEIGHT: height_reg = val;
        default: return;
      endcase
      col_pos = 0;
      row_pos = 0;
    endfunction

    function chan_t chan_of(pix_in_t px, int ch);
      case (ch)
        0:       return px.chan_a;
        1:       return px.chan_b;
        default: return px.chan_c;
      endcase
    endfunction

    // (max + min) / 2 with an exact half going to the even neighbor.
    function chan_t midpoint(int ch);
      chan_t      lo;
      chan_t      hi;
      chan_t      v;
      logic [8:0] total;
      logic [7:0] half;
      lo = '1;
      hi = '0;
      foreach (win[i, j]) begin
        v = chan_of(win[i][j], ch);
        if (v < lo) lo = v;
        if (v > hi) hi = v;
      end
      total = {1'b0, lo} + {1'b0, hi};
      half  = total[8:1];
      if (total[0] && half[0]) half = half + 8'd1;
      return half;
    endfunction

    function void absorb_pixel(pix_in_t px);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      pix_in_t     above2;
      pix_in_t     above1;
      result_t     due;
      w = eff_width();
      h = eff_height();
      c = (col_pos >= w) ? 0 : col_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      above2       = older_row[c];
      above1       = prev_row[c];
      older_row[c] = above1;
      prev_row[c]  = px;
      for (int i = 0; i < KERNEL_SIZE; i++) begin
        for (int j = 0; j < KERNEL_SIZE - 1; j++) win[i][j] = win[i][j+1];
      end
      win[0][KERNEL_SIZE-1] = above2;
      win[1][KERNEL_SIZE-1] = above1;
      win[2][KERNEL_SIZE-1] = px;
      if (r >= KERNEL_SIZE - 1 && c >= KERNEL_SIZE - 1) begin
        due.out_a   = midpoint(0);
        due.out_b   = midpoint(1);
        due.out_c   = midpoint(2);
        due.out_row = COORD_W'(r - KERNEL_SIZE / 2);
        due.out_col = COORD_W'(c - KERNEL_SIZE / 2);
        owed_words.push_back(due);
      end
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want, result_t due);
      if (got !== want)
        report($sformatf("%s at row %0d col %0d: got %0d, want %0d",
                         name, due.out_row, due.out_col, got, want));
    endtask

    task check_result(result_t got);
      result_t due;
      if (owed_words.size() == 0) begin
        report($sformatf("unexpected word for row %0d col %0d", got.out_row, got.out_col));
        return;
      end
      due = owed_words.pop_front();
      check_field("out_a", 16'(got.out_a), 16'(due.out_a), due);
      check_field("out_b", 16'(got.out_b), 16'(due.out_b), due);
      check_field("out_c", 16'(got.out_c), 16'(due.out_c), due);
      check_field("out_row", 16'(got.out_row), 16'(due.out_row), due);
      check_field("out_col", 16'(got.out_col), 16'(due.out_col), due);
    endtask

  endclass

endpackage

`default_nettype wire

// ----- tb/midpoint_filter_3x3_rgb_tb.sv -----
// Self-checking testbench for the 3x3 midpoint filter: random raster frames against a predictor.
`default_nettype none

module midpoint_filter_3x3_rgb_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import mpf_pkg::*;
  import mpf_scoreboard_pkg::*;

  // Register indexes past the end of the register list; writes there are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  localparam int unsigned RANDOM_ITEMS  = 150;
  localparam int unsigned PHASE_ITEMS   = 60;     // most pixels in one random phase
  localparam int unsigned SETTLE_CYCLES = 12;     // line store read + window + lanes, plus margin
  localparam int unsigned RUN_LIMIT_NS  = 10_000_000;

  typedef enum int {
    STY_UNIFORM,
    STY_BAND,
    STY_EDGE,
    STY_MIXED
  } pixel_style_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  pix_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  result_t              out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  midpoint_scoreboard sb = new();

  // Idle knobs, changed per phase: chance in percent of starting a burst.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned band_lo   = 0;
  int unsigned random_count = 0;

  midpoint_filter_3x3_rgb u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hold stall high in random bursts, independent of the result valid.
  always @(posedge clk) begin
    if (rst || stall_pct == 0) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Values read here are the ones from before the edge, so a word counts when
  // valid was high and stall low during the cycle that just ended.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // One channel byte in the given style; band values sit at most 3 above band_lo so
  // that max and min fall close together and exact halves come up often.
  function automatic chan_t pick_chan(pixel_style_e style);
    pixel_style_e s;
    s = (style == STY_MIXED) ? pixel_style_e'($urandom_range(0, 2)) : style;
    case (s)
      STY_BAND: return chan_t'(band_lo + $urandom_range(0, 3));
      STY_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return 8'd0;
          1:       return 8'd255;
          2:       return 8'd1;
          default: return 8'd254;
        endcase
      end
      default: return chan_t'($urandom);
    endcase
  endfunction

  function automatic pix_in_t make_pixel(pixel_style_e style);
    pix_in_t px;
    px.chan_a = pick_chan(style);
    px.chan_b = pick_chan(style);
    px.chan_c = pick_chan(style);
    return px;
  endfunction

  // Hand-built 3x3 frames; the last pixel of each frame yields the only word.
  //   frame 0: a = one 255 among zeros (127.5 goes up to 128), b = flat 255,
  //            c = 1..4 (2.5 goes down to 2)
  //   frame 1: a = flat 0, b = a single 1 (0.5 goes to 0), c = 254/255 (to 254)
  //   frame 2: a = AA/55 checker (to 128), b = 127/128 (to 128), c = 3..5 (to 4)
  function automatic pix_in_t directed_pixel(int unsigned frame, int unsigned k);
    pix_in_t px;
    case (frame)
      0: begin
        px.chan_a = (k == 0) ? 8'd255 : 8'd0;
        px.chan_b = 8'd255;
        px.chan_c = chan_t'(1 + k % 4);
      end
      1: begin
        px.chan_a = 8'd0;
        px.chan_b = (k == 4) ? 8'd1 : 8'd0;
        px.chan_c = chan_t'(254 + k % 2);
      end
      default: begin
        px.chan_a = (k % 2 != 0) ? 8'h55 : 8'hAA;
        px.chan_b = chan_t'(127 + (k == 8));
        px.chan_c = chan_t'(3 + k % 3);
      end
    endcase
    return px;
  endfunction

  // Mostly small sizes, sometimes below the minimum so the clamp is exercised.
  function automatic logic [CFG_W-1:0] pick_dim(int unsigned biggest);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return CFG_W'($urandom_range(0, MIN_DIM - 1));
    if (roll < 80) return CFG_W'($urandom_range(MIN_DIM, 8));
    return CFG_W'($urandom_range(9, biggest));
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // Present one word and hold it until taken, then maybe drop valid for a burst.
  task automatic send_pixel(input pix_in_t px);
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.absorb_pixel(px);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic stream_pixels(input int unsigned count, input pixel_style_e style);
    for (int unsigned k = 0; k < count; k++) send_pixel(make_pixel(style));
    in_valid <= 1'b0;
  endtask

  // Write one register, then drop cfg_we before returning so we never toggle in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every owed word, then let any pixel still in the pipe drain out.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random phase: new sizes (or a spare write that must not restart the
  // frame), then a stream of one to two frames of pixels, cut at PHASE_ITEMS.
  task automatic random_phase();
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;
    int unsigned      n;
    int unsigned      area;
    drain();
    wv = pick_dim(40);
    hv = pick_dim(12);
    case ($urandom_range(0, 5))
      0: write_reg(REG_IMAGE_WIDTH, wv);
      1: write_reg(REG_IMAGE_HEIGHT, hv);
      2, 3: begin
        write_reg(REG_IMAGE_WIDTH, wv);
        write_reg(REG_IMAGE_HEIGHT, hv);
      end
      4: begin
        write_reg(REG_IMAGE_HEIGHT, hv);
        write_reg(REG_IMAGE_WIDTH, wv);
      end
      default: write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, CFG_W'($urandom));
    endcase
    gap_pct   = pick_pct();
    stall_pct = pick_pct();
    band_lo   = $urandom_range(0, 252);
    area = sb.eff_width() * sb.eff_height();
    n    = area + $urandom_range(0, area);
    if (n > PHASE_ITEMS) n = PHASE_ITEMS;
    stream_pixels(n, pixel_style_e'($urandom_range(0, 3)));
    random_count += n;
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes (640 x 480): two full rows and the start of a third.
    gap_pct   = 20;
    stall_pct = 20;
    stream_pixels(2 * WIDTH_RESET + 20, STY_UNIFORM);

    // Directed frames; width 0 and height 2 both clamp up to 3.
    drain();
    write_reg(REG_IMAGE_WIDTH, CFG_W'(0));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
    for (int unsigned k = 0; k < 22; k++) send_pixel(directed_pixel(k / 9, k % 9));
    in_valid <= 1'b0;
    // A spare write in mid-frame must leave the position alone.
    drain();
    write_reg(REG_SPARE_LO, CFG_W'(1));
    for (int unsigned k = 22; k < 27; k++) send_pixel(directed_pixel(k / 9, k % 9));
    in_valid <= 1'b0;

    while (random_count < RANDOM_ITEMS) random_phase();

    // Tall frame: height saturates at 2048, so thirty narrow rows never wrap.
    drain();
    gap_pct   = 15;
    stall_pct = 15;
    write_reg(REG_IMAGE_WIDTH, CFG_W'(MIN_DIM));
    write_reg(REG_IMAGE_HEIGHT, '1);
    stream_pixels(MIN_DIM * 30, STY_MIXED);

    // Last frame at full rate, no idling on either side, then wrap into a new frame.
    drain();
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(REG_IMAGE_WIDTH, CFG_W'(32));
    write_reg(REG_IMAGE_HEIGHT, CFG_W'(MIN_DIM));
    stream_pixels(MIN_DIM * 32 + 5, STY_MIXED);

    drain();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
